// ----- hdl/crnc_pkg.sv -----
// ----------------------------------------------------------------------------
// crnc_pkg
// Shared types and codes of the six-relay CAN node controller.
// ----------------------------------------------------------------------------
`default_nettype none

package crnc_pkg;

  localparam int unsigned TBL_DEPTH  = 22;
  localparam int unsigned MAX_FRAMES = 7;
  localparam int unsigned CNT_W      = 3;
  localparam int unsigned NUM_CH     = 6;
  localparam int unsigned PAGE_LEN   = 7;

  // table layout
  localparam int unsigned IDX_CFG     = 0;
  localparam int unsigned IDX_NODE_ID = 1;
  localparam int unsigned IDX_UNPROG  = 2;
  localparam int unsigned IDX_SPARE   = 3;
  localparam int unsigned IDX_RELAY   = 10;
  localparam int unsigned IDX_MODE    = 16;
  localparam int unsigned IDX_EXT     = 21;

  // item kinds
  localparam logic ITEM_FRAME  = 1'b0;
  localparam logic ITEM_SAMPLE = 1'b1;

  // received command codes
  localparam logic [7:0] CMD_SET_RELAY = 8'd0;
  localparam logic [7:0] CMD_QUERY     = 8'd2;
  localparam logic [7:0] CMD_PROBE     = 8'd0;
  localparam logic [7:0] CMD_DUMP_0    = 8'd1;
  localparam logic [7:0] CMD_DUMP_1    = 8'd2;
  localparam logic [7:0] CMD_DUMP_2    = 8'd3;
  localparam logic [7:0] CMD_READ_EXT  = 8'd4;
  localparam logic [7:0] CMD_WRITE_0   = 8'd7;
  localparam logic [7:0] CMD_WRITE_1   = 8'd8;
  localparam logic [7:0] CMD_WRITE_2   = 8'd9;
  localparam logic [7:0] CMD_WRITE_EXT = 8'd16;

  // reply codes
  localparam logic [7:0] RPL_OK      = 8'h01;
  localparam logic [7:0] RPL_ZERO    = 8'h00;
  localparam logic [7:0] RPL_NODE_0  = 8'h05;
  localparam logic [7:0] RPL_NODE_1  = 8'h02;
  localparam logic [7:0] RPL_NODE_2  = 8'h06;
  localparam logic [7:0] RPL_PAGE_0  = 8'h0A;
  localparam logic [7:0] RPL_PAGE_1  = 8'h0B;
  localparam logic [7:0] RPL_PAGE_2  = 8'h0C;
  localparam logic [7:0] RPL_EXT     = 8'h0D;

  // input modes
  localparam logic [7:0] MODE_EDGE = 8'd1;
  localparam logic [7:0] MODE_LOW  = 8'd2;
  localparam logic [7:0] MODE_HIGH = 8'd3;

  typedef struct packed {
    logic        cmd;
    logic [10:0] frame_id;
    logic [7:0]  rx_byte0;
    logic [7:0]  rx_byte1;
    logic [7:0]  rx_byte2;
    logic [7:0]  rx_byte3;
    logic [7:0]  rx_byte4;
    logic [7:0]  rx_byte5;
    logic [7:0]  rx_byte6;
    logic [7:0]  rx_byte7;
    logic [5:0]  switch_levels;
    logic        mode_button;
  } in_item_t;

  typedef struct packed {
    logic [10:0] tx_id;
    logic [3:0]  tx_len;
    logic [7:0]  tx_byte0;
    logic [7:0]  tx_byte1;
    logic [7:0]  tx_byte2;
    logic [7:0]  tx_byte3;
    logic [7:0]  tx_byte4;
    logic [7:0]  tx_byte5;
    logic [7:0]  tx_byte6;
    logic [7:0]  tx_byte7;
    logic [5:0]  relay_on;
    logic        last;
  } out_item_t;

  // one outgoing frame body, data[i] is byte i
  typedef struct packed {
    logic [3:0]      len;
    logic [7:0][7:0] data;
  } frame_t;

  // all frames caused by one item
  typedef struct packed {
    logic [10:0]                   tx_id;
    logic [5:0]                    relay_on;
    logic [CNT_W-1:0]              cnt;
    frame_t [MAX_FRAMES-1:0]       frames;
  } batch_t;

endpackage

`default_nettype wire

// ----- hdl/crnc_core.sv -----
// ----------------------------------------------------------------------------
// crnc_core
// Code table, switch history and the single-pass decode of one item.
// ----------------------------------------------------------------------------
`default_nettype none

module crnc_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  crnc_pkg::in_item_t item_i,
  input  logic              fire_i,
  output crnc_pkg::batch_t  batch_o
);

  logic [7:0] tbl_q [crnc_pkg::TBL_DEPTH];
  logic [7:0] tbl_d [crnc_pkg::TBL_DEPTH];
  logic [6:0] prev_q;
  logic [6:0] prev_d;

  crnc_pkg::frame_t                        cand [crnc_pkg::MAX_FRAMES];
  logic [crnc_pkg::MAX_FRAMES-1:0]         cand_v;
  logic [7:0]                              rxb [8];
  logic                                    id_match;
  logic                                    hit;
  logic [7:0]                              newv;
  logic [crnc_pkg::CNT_W-1:0]              pos;
  crnc_pkg::frame_t [crnc_pkg::MAX_FRAMES-1:0] frames;

  function automatic crnc_pkg::frame_t mk_status(input logic [7:0] ch, input logic [7:0] val);
    crnc_pkg::frame_t f;
    f         = '0;
    f.len     = 4'd4;
    f.data[0] = crnc_pkg::RPL_OK;
    f.data[1] = ch;
    f.data[2] = val;
    return f;
  endfunction

  function automatic crnc_pkg::frame_t mk_probe(input logic [3:0] len, input logic [7:0] cfg);
    crnc_pkg::frame_t f;
    f         = '0;
    f.len     = len;
    f.data[0] = crnc_pkg::RPL_NODE_0;
    f.data[1] = crnc_pkg::RPL_NODE_1;
    f.data[2] = crnc_pkg::RPL_NODE_2;
    f.data[3] = (len == 4'd4) ? cfg : 8'd0;
    return f;
  endfunction

  function automatic crnc_pkg::frame_t mk_page(input logic [7:0] code,
                                               input logic [7:0] t [crnc_pkg::TBL_DEPTH],
                                               input int unsigned base);
    crnc_pkg::frame_t f;
    f         = '0;
    f.len     = 4'd8;
    f.data[0] = code;
    for (int i = 0; i < crnc_pkg::PAGE_LEN; i++) begin
      f.data[i+1] = t[base+i];
    end
    return f;
  endfunction

  assign rxb[0] = item_i.rx_byte0;
  assign rxb[1] = item_i.rx_byte1;
  assign rxb[2] = item_i.rx_byte2;
  assign rxb[3] = item_i.rx_byte3;
  assign rxb[4] = item_i.rx_byte4;
  assign rxb[5] = item_i.rx_byte5;
  assign rxb[6] = item_i.rx_byte6;
  assign rxb[7] = item_i.rx_byte7;

  assign id_match = (item_i.frame_id == {3'b000, tbl_q[crnc_pkg::IDX_NODE_ID]});

  always_comb begin
    tbl_d  = tbl_q;
    prev_d = prev_q;
    cand_v = '0;
    hit    = 1'b0;
    newv   = '0;
    for (int i = 0; i < crnc_pkg::MAX_FRAMES; i++) begin
      cand[i] = '0;
    end

    if (item_i.cmd == crnc_pkg::ITEM_FRAME) begin
      if (tbl_q[crnc_pkg::IDX_CFG] == 8'd0) begin
        // normal mode
        if (tbl_q[crnc_pkg::IDX_UNPROG] == 8'd0 && id_match) begin
          if (rxb[0] == crnc_pkg::CMD_SET_RELAY) begin
            for (int k = 0; k < crnc_pkg::NUM_CH; k++) begin
              if (rxb[1] == 8'(k + 1)) begin
                tbl_d[crnc_pkg::IDX_RELAY+k] = {7'd0, rxb[2] != 8'd0};
                cand_v[0] = 1'b1;
                cand[0]   = mk_status(rxb[1], {7'd0, rxb[2] != 8'd0});
              end
            end
          end else if (rxb[0] == crnc_pkg::CMD_QUERY) begin
            for (int k = 0; k < crnc_pkg::NUM_CH; k++) begin
              if (rxb[1] == 8'(k + 1)) begin
                cand_v[0] = 1'b1;
                cand[0]   = mk_status(rxb[1], tbl_q[crnc_pkg::IDX_RELAY+k]);
              end
            end
            if (rxb[1] == 8'd0 && rxb[2] == 8'd0) begin
              cand_v[0]       = 1'b1;
              cand[0].len     = 4'd8;
              cand[0].data[0] = crnc_pkg::RPL_OK;
              cand[0].data[1] = crnc_pkg::RPL_ZERO;
              for (int k = 0; k < crnc_pkg::NUM_CH; k++) begin
                cand[0].data[k+2] = tbl_q[crnc_pkg::IDX_RELAY+k];
              end
            end
          end
        end
      end else if (id_match) begin
        // config mode
        unique case (rxb[0])
          crnc_pkg::CMD_PROBE: begin
            cand_v[0] = 1'b1;
            cand[0]   = mk_probe(4'd4, tbl_q[crnc_pkg::IDX_CFG]);
          end
          crnc_pkg::CMD_DUMP_0: begin
            cand_v[0] = 1'b1;
            cand[0]   = mk_page(crnc_pkg::RPL_PAGE_0, tbl_q, 0);
          end
          crnc_pkg::CMD_DUMP_1: begin
            cand_v[0] = 1'b1;
            cand[0]   = mk_page(crnc_pkg::RPL_PAGE_1, tbl_q, crnc_pkg::PAGE_LEN);
          end
          crnc_pkg::CMD_DUMP_2: begin
            cand_v[0] = 1'b1;
            cand[0]   = mk_page(crnc_pkg::RPL_PAGE_2, tbl_q, 2 * crnc_pkg::PAGE_LEN);
          end
          crnc_pkg::CMD_READ_EXT: begin
            cand_v[0]       = 1'b1;
            cand[0].len     = 4'd2;
            cand[0].data[0] = crnc_pkg::RPL_EXT;
            cand[0].data[1] = tbl_q[crnc_pkg::IDX_EXT];
          end
          crnc_pkg::CMD_WRITE_0: begin
            for (int i = 0; i < crnc_pkg::PAGE_LEN; i++) begin
              tbl_d[i] = rxb[i+1];
            end
            cand_v[0]       = 1'b1;
            cand[0].len     = 4'd1;
            cand[0].data[0] = crnc_pkg::RPL_OK;
          end
          crnc_pkg::CMD_WRITE_1: begin
            for (int i = 0; i < crnc_pkg::PAGE_LEN; i++) begin
              tbl_d[crnc_pkg::PAGE_LEN+i] = rxb[i+1];
            end
            cand_v[0]       = 1'b1;
            cand[0].len     = 4'd1;
            cand[0].data[0] = crnc_pkg::RPL_OK;
          end
          crnc_pkg::CMD_WRITE_2: begin
            for (int i = 0; i < crnc_pkg::PAGE_LEN; i++) begin
              tbl_d[2*crnc_pkg::PAGE_LEN+i] = rxb[i+1];
            end
            cand_v[0]       = 1'b1;
            cand[0].len     = 4'd1;
            cand[0].data[0] = crnc_pkg::RPL_OK;
          end
          crnc_pkg::CMD_WRITE_EXT: begin
            tbl_d[crnc_pkg::IDX_EXT] = rxb[1];
            cand_v[0]       = 1'b1;
            cand[0].len     = 4'd1;
            cand[0].data[0] = crnc_pkg::RPL_OK;
          end
          default: begin
          end
        endcase
      end

      // broadcast probe, judged on the updated table
      if (item_i.frame_id == 11'd0 && rxb[0] == crnc_pkg::CMD_PROBE &&
          (tbl_d[crnc_pkg::IDX_CFG] | tbl_d[crnc_pkg::IDX_SPARE] |
           tbl_d[crnc_pkg::IDX_UNPROG]) != 8'd0) begin
        cand_v[1] = 1'b1;
        cand[1]   = mk_probe(4'd4, tbl_d[crnc_pkg::IDX_CFG]);
      end
    end else begin
      // button press edge toggles config mode
      if (prev_q[6] && !item_i.mode_button) begin
        if (tbl_q[crnc_pkg::IDX_CFG] != 8'd0) begin
          tbl_d[crnc_pkg::IDX_CFG] = 8'd0;
        end else begin
          tbl_d[crnc_pkg::IDX_CFG] = 8'd1;
          cand_v[0] = 1'b1;
          cand[0]   = mk_probe(4'd3, 8'd0);
        end
      end
      for (int k = 0; k < crnc_pkg::NUM_CH; k++) begin
        hit = 1'b0;
        priority if (tbl_q[crnc_pkg::IDX_MODE+k] == crnc_pkg::MODE_EDGE) begin
          hit = prev_q[k] && !item_i.switch_levels[k];
        end else if (tbl_q[crnc_pkg::IDX_MODE+k] == crnc_pkg::MODE_LOW) begin
          if (!item_i.switch_levels[k]) begin
            hit = 1'b1;
            tbl_d[crnc_pkg::IDX_MODE+k] = crnc_pkg::MODE_HIGH;
          end
        end else if (tbl_q[crnc_pkg::IDX_MODE+k] == crnc_pkg::MODE_HIGH) begin
          if (item_i.switch_levels[k]) begin
            hit = 1'b1;
            tbl_d[crnc_pkg::IDX_MODE+k] = crnc_pkg::MODE_LOW;
          end
        end else begin
          hit = 1'b0;
        end
        newv = {7'd0, tbl_q[crnc_pkg::IDX_RELAY+k] == 8'd0};
        if (hit) begin
          tbl_d[crnc_pkg::IDX_RELAY+k] = newv;
          cand_v[k+1] = 1'b1;
          cand[k+1]   = mk_status(8'(k + 1), newv);
        end
      end
      prev_d = {item_i.mode_button, item_i.switch_levels};
    end
  end

  // pack the emitted frames into consecutive slots
  always_comb begin
    pos    = '0;
    frames = '0;
    for (int i = 0; i < crnc_pkg::MAX_FRAMES; i++) begin
      if (cand_v[i]) begin
        frames[pos] = cand[i];
        pos         = pos + crnc_pkg::CNT_W'(1);
      end
    end
  end

  always_comb begin
    batch_o.tx_id  = {3'b000, tbl_d[crnc_pkg::IDX_NODE_ID]};
    batch_o.cnt    = pos;
    batch_o.frames = frames;
    for (int k = 0; k < crnc_pkg::NUM_CH; k++) begin
      batch_o.relay_on[k] = (tbl_d[crnc_pkg::IDX_RELAY+k] != 8'd0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < crnc_pkg::TBL_DEPTH; i++) begin
        tbl_q[i] <= 8'd0;
      end
      tbl_q[crnc_pkg::IDX_UNPROG] <= 8'd1;
      prev_q <= '1;
    end else if (fire_i) begin
      tbl_q  <= tbl_d;
      prev_q <= prev_d;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/crnc_txq.sv -----
// ----------------------------------------------------------------------------
// crnc_txq
// Result register: holds the frames of one item and shifts them out in order.
// ----------------------------------------------------------------------------
`default_nettype none

module crnc_txq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  crnc_pkg::batch_t    batch_i,
  output logic                ready_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output crnc_pkg::out_item_t out_data_o
);

  crnc_pkg::frame_t [crnc_pkg::MAX_FRAMES-1:0] fr_q;
  crnc_pkg::frame_t [crnc_pkg::MAX_FRAMES-1:0] fr_d;
  logic [crnc_pkg::CNT_W-1:0]                 cnt_q;
  logic [crnc_pkg::CNT_W-1:0]                 cnt_d;
  logic [10:0]                                id_q;
  logic [5:0]                                 relay_q;
  logic                                       pop;

  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  // free now, or the last frame leaves this cycle
  assign ready_o     = (cnt_q == '0) || (pop && cnt_q == crnc_pkg::CNT_W'(1));

  always_comb begin
    fr_d  = fr_q;
    cnt_d = cnt_q;
    if (load_i) begin
      fr_d  = batch_i.frames;
      cnt_d = batch_i.cnt;
    end else if (pop) begin
      for (int i = 0; i < crnc_pkg::MAX_FRAMES - 1; i++) begin
        fr_d[i] = fr_q[i+1];
      end
      fr_d[crnc_pkg::MAX_FRAMES-1] = '0;
      cnt_d = cnt_q - crnc_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fr_q <= fr_d;
    if (load_i) begin
      id_q    <= batch_i.tx_id;
      relay_q <= batch_i.relay_on;
    end
  end

  always_comb begin
    out_data_o.tx_id    = id_q;
    out_data_o.tx_len   = fr_q[0].len;
    out_data_o.tx_byte0 = fr_q[0].data[0];
    out_data_o.tx_byte1 = fr_q[0].data[1];
    out_data_o.tx_byte2 = fr_q[0].data[2];
    out_data_o.tx_byte3 = fr_q[0].data[3];
    out_data_o.tx_byte4 = fr_q[0].data[4];
    out_data_o.tx_byte5 = fr_q[0].data[5];
    out_data_o.tx_byte6 = fr_q[0].data[6];
    out_data_o.tx_byte7 = fr_q[0].data[7];
    out_data_o.relay_on = relay_q;
    out_data_o.last     = (cnt_q == crnc_pkg::CNT_W'(1));
  end

endmodule

`default_nettype wire

// ----- hdl/can_relay_node_controller.sv -----
// ----------------------------------------------------------------------------
// can_relay_node_controller
// Six-relay node controller driven by CAN frames and local switch samples.
//
// Input channel (in_valid_i / in_stall_o / in_data_i): one transaction is
// either a received CAN frame (cmd 0) or a sample of switch and button levels
// (cmd 1). Output channel (out_valid_o / out_stall_i / out_data_o): one
// transaction per reply or status frame, 0 to 7 per input item, the last one
// flagged with last. All frames of an item carry the node id and relay states
// as they stand after that item.
// Flow: an item is captured in the input register and decoded there in one
// pass; when it fires, its frames land in the result register, from which
// the first frame is presented on the output channel.
// Throughput: an item that emits frames holds the result register until all
// have left (one frame per cycle while out_stall_i is low); an item that
// emits nothing passes without waiting, even while earlier frames drain. The
// next item is taken while the last frame of the previous one leaves.
// Reset: code table back to defaults (node unprogrammed), switch history
// released, both registers empty. A stalled receiver holds the current frame
// and, once the input register is full, stalls the input channel.
// ----------------------------------------------------------------------------
`default_nettype none

module can_relay_node_controller (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  crnc_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output crnc_pkg::out_item_t out_data_o
);

  // input register
  logic               in_vq;
  crnc_pkg::in_item_t in_q;

  // decode results for the item in the input register
  crnc_pkg::batch_t batch;
  logic             txq_ready;
  logic             fire;
  logic             load;

  // an item with no frames never waits for the result register
  assign fire       = in_vq && (txq_ready || batch.cnt == '0);
  assign load       = fire && (batch.cnt != '0);
  assign in_stall_o = in_vq && !fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vq <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_vq <= 1'b1;
    end else if (fire) begin
      in_vq <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
  end

  // table state and single-pass decode; state commits when the item fires
  crnc_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (in_q),
    .fire_i  (fire),
    .batch_o (batch)
  );

  // result register, drains the frames of one item in order
  crnc_txq u_txq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .batch_i     (batch),
    .ready_o     (txq_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ----- hdl/crnc_checker.sv -----
// ----------------------------------------------------------------------------
// crnc_checker
// Port-level checks of the relay node controller, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module crnc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input crnc_pkg::in_item_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input crnc_pkg::out_item_t out_data_o
);

  // stalled frame holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output frame changed");

  // frame length in range
  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.tx_len != 4'd0 && out_data_o.tx_len <= 4'd8)
    else $error("frame length out of range");

  // frames of one item follow without a gap and share id and relay states
  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.last |=>
      out_valid_o && out_data_o.tx_id == $past(out_data_o.tx_id) &&
      out_data_o.relay_on == $past(out_data_o.relay_on))
    else $error("frames of one item split or inconsistent");

  // with nothing waiting at the output the input is never stalled
  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

endmodule

bind can_relay_node_controller crnc_checker u_crnc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
